[src/swma_pkg.sv]
// Shared types and constants for the sliding window moving average block.
package swma_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int WLEN_W         = 7;
  localparam int WLEN_RESET     = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = WLEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = 1'd1;

  localparam logic MODE_SMA = 1'b0;
  localparam logic MODE_WMA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_UPD,
    ST_START,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic read_ring;
    logic multiply;
    logic update;
    logic div_start;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic series_ready;
    logic div_done;
  } dp_status_t;

endpackage

[src/sliding_window_moving_average.sv]
// Sliding window moving average: top level joining controller and datapath.
// One transaction in, one result out. Each sample updates a ring of the last N
// samples, a running sum and a linearly weighted sum; the average (sum/N or
// weighted sum/(N(N+1)/2), truncated toward zero) comes from a shared
// one-bit-per-cycle divider, which is started only once the window is full;
// an item taken before then skips the division and its result is not ready.
// A finished result waits in the output register while the next sample is
// taken. Writing window_length starts a new series; average_mode applies
// from the next sample on.
module sliding_window_moving_average #(
  parameter int MAX_WINDOW = swma_pkg::MAX_WINDOW_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [swma_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  first_of_series_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [swma_pkg::SAMPLE_W-1:0]  average_o,
  output logic                                  ready_res_o,
  input  logic                                  cfg_we_i,
  input  logic [swma_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [swma_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  swma_pkg::dp_cmd_t    cmd;
  swma_pkg::dp_status_t status;

  swma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  swma_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .sample_i          (sample_i),
    .first_of_series_i (first_of_series_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .average_o         (average_o),
    .ready_res_o       (ready_res_o)
  );

endmodule

[src/swma_div.sv]
// Iterative signed divider, one quotient bit per cycle while step_i is high, truncating toward zero.
module swma_div #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 14,
  parameter int QUO_W      = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         step_i,
  input  logic signed [DIVIDEND_W-1:0] dividend_i,
  input  logic        [DIVISOR_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic        [QUO_W-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  den_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVIDEND_W-1:0] mag;
  logic [DIVIDEND_W-1:0] signed_quo;

  assign mag   = dividend_i[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend_i) : DIVIDEND_W'(dividend_i);
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = mag;
      rem_d = '0;
      cnt_d = CNT_W'(DIVIDEND_W);
    end else if (step_i && cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
      neg_q <= dividend_i[DIVIDEND_W-1];
    end
  end

  assign signed_quo = neg_q ? (~quo_q + DIVIDEND_W'(1)) : quo_q;
  assign quotient_o = signed_quo[QUO_W-1:0];
  assign done_o     = (cnt_q == '0);

endmodule

[src/swma_dp.sv]
// Datapath: sample ring, running sums, divider and result register.
module swma_dp #(
  parameter int MAX_WINDOW = swma_pkg::MAX_WINDOW_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  swma_pkg::dp_cmd_t                     cmd_i,
  output swma_pkg::dp_status_t                  status_o,
  input  logic signed [swma_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  first_of_series_i,
  input  logic                                  cfg_we_i,
  input  logic [swma_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [swma_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output logic signed [swma_pkg::SAMPLE_W-1:0]  average_o,
  output logic                                  ready_res_o
);

  localparam int SW      = swma_pkg::SAMPLE_W;
  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int NW      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SW + AW + 2;
  localparam int WSUM_W  = SW + 2 * AW + 4;
  localparam int DEN_W   = 2 * NW;
  localparam int RESET_N = (swma_pkg::WLEN_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                              : swma_pkg::WLEN_RESET;

  logic [SW-1:0]            ring_q [MAX_WINDOW];
  logic signed [SW-1:0]     x_q;
  logic signed [SW-1:0]     leaving_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [WSUM_W-1:0] wsum_q;
  logic signed [WSUM_W-1:0] prod_q;
  logic [DEN_W-1:0]         denom_q;
  logic [NW-1:0]            n_q;
  logic [NW-1:0]            fill_q;
  logic [AW-1:0]            pos_q;
  logic                     mode_q;
  logic                     full_q;
  logic                     ready_q;
  logic signed [SW-1:0]     avg_q;

  logic [NW-1:0]            cfg_len;
  logic                     wlen_we;
  logic                     clear;
  logic                     filling;
  logic [NW-1:0]            factor;
  logic signed [SW+NW:0]    prod_full;
  logic [NW-1:0]            pos_next;
  logic signed [WSUM_W-1:0] dividend;
  logic [DEN_W-1:0]         divisor;
  logic                     div_done;
  logic [SW-1:0]            quotient;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_len = NW'(1);
    end else if (int'(cfg_wdata_i) > MAX_WINDOW) begin
      cfg_len = NW'(MAX_WINDOW);
    end else begin
      cfg_len = NW'(cfg_wdata_i);
    end
  end

  assign wlen_we   = cfg_we_i && (cfg_index_i == swma_pkg::REG_WINDOW_LENGTH);
  assign clear     = wlen_we || (cmd_i.accept && first_of_series_i);
  assign filling   = (fill_q < n_q);
  assign factor    = filling ? (fill_q + NW'(1)) : n_q;
  assign prod_full = x_q * $signed({1'b0, factor});
  assign pos_next  = NW'(pos_q) + NW'(1);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= NW'(RESET_N);
      mode_q <= swma_pkg::MODE_SMA;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        swma_pkg::REG_WINDOW_LENGTH: n_q    <= cfg_len;
        swma_pkg::REG_AVERAGE_MODE:  mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      wsum_q  <= '0;
      fill_q  <= '0;
      pos_q   <= '0;
      full_q  <= 1'b0;
    end else if (clear) begin
      sum_q   <= '0;
      wsum_q  <= '0;
      fill_q  <= '0;
      pos_q   <= '0;
    end else if (cmd_i.update) begin
      if (filling) begin
        fill_q <= fill_q + NW'(1);
        wsum_q <= wsum_q + prod_q;
        sum_q  <= sum_q + SUM_W'(x_q);
        full_q <= ((fill_q + NW'(1)) == n_q);
      end else begin
        wsum_q <= wsum_q - WSUM_W'(sum_q) + prod_q;
        sum_q  <= sum_q - SUM_W'(leaving_q) + SUM_W'(x_q);
        full_q <= 1'b1;
      end
      pos_q <= (pos_next >= n_q) ? '0 : AW'(pos_next);
    end
  end

  // ring and operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
    if (cmd_i.read_ring) begin
      leaving_q <= ring_q[pos_q];
    end
    if (cmd_i.multiply) begin
      prod_q  <= WSUM_W'(prod_full);
      denom_q <= DEN_W'((DEN_W'(n_q) * (DEN_W'(n_q) + DEN_W'(1))) >> 1);
    end
    if (cmd_i.update) begin
      ring_q[pos_q] <= x_q;
    end
  end

  assign dividend = (mode_q == swma_pkg::MODE_WMA) ? wsum_q : WSUM_W'(sum_q);
  assign divisor  = (mode_q == swma_pkg::MODE_WMA) ? denom_q : DEN_W'(n_q);

  swma_div #(
    .DIVIDEND_W (WSUM_W),
    .DIVISOR_W  (DEN_W),
    .QUO_W      (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      avg_q   <= full_q ? $signed(quotient) : '0;
      ready_q <= full_q;
    end
  end

  assign status_o.series_ready = full_q;
  assign status_o.div_done     = div_done;
  assign average_o             = avg_q;
  assign ready_res_o           = ready_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= n_q)
    else $error("fill count exceeds window length");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(pos_q) < n_q)
    else $error("write position outside window");

endmodule

[src/swma_ctrl.sv]
// Controller: sequences one transaction through ring read, sum update and division.
module swma_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output swma_pkg::dp_cmd_t    cmd_o,
  input  swma_pkg::dp_status_t status_i
);

  swma_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swma_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    unique case (state_q)
      swma_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = swma_pkg::ST_READ;
        end
      end
      swma_pkg::ST_READ: begin
        cmd_o.read_ring = 1'b1;
        state_d         = swma_pkg::ST_MUL;
      end
      swma_pkg::ST_MUL: begin
        cmd_o.multiply = 1'b1;
        state_d        = swma_pkg::ST_UPD;
      end
      swma_pkg::ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = swma_pkg::ST_START;
      end
      swma_pkg::ST_START: begin
        if (status_i.series_ready) begin
          cmd_o.div_start = 1'b1;
          state_d         = swma_pkg::ST_DIV;
        end else begin
          state_d = swma_pkg::ST_DONE;
        end
      end
      swma_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = swma_pkg::ST_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      swma_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = swma_pkg::ST_IDLE;
        end
      end
      default: state_d = swma_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == swma_pkg::ST_DONE))
    else $error("result valid raised outside completion");

  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swma_pkg::ST_DONE && out_valid_q && out_stall_i)
      |=> state_q == swma_pkg::ST_DONE)
    else $error("result overwritten while output stalled");

endmodule
